/* src/cbsu_pkg.sv */
// Shared types and constants for the CB-prefix bit and shift unit.
// Used by the register file, execute logic, top level and testbench; depends on nothing.
package cbsu_pkg;

  // Flag bit positions in the flag byte.
  localparam int unsigned FlagS = 7;
  localparam int unsigned FlagZ = 6;
  localparam int unsigned FlagH = 4;
  localparam int unsigned FlagP = 2;
  localparam int unsigned FlagN = 1;
  localparam int unsigned FlagC = 0;

  // Flag bits this unit never touches (the undocumented bits 5 and 3).
  localparam logic [7:0] FlagKeepMask = 8'h28;

  // Operand select that names the memory byte instead of a register.
  localparam logic [2:0] SelMemory = 3'd6;

  // Instruction class in opcode bits 7..6.
  typedef enum logic [1:0] {
    CLS_SHIFT = 2'd0,
    CLS_BIT   = 2'd1,
    CLS_RES   = 2'd2,
    CLS_SET   = 2'd3
  } cls_t;

  // Rotate and shift kind in opcode bits 5..3.
  typedef enum logic [2:0] {
    SK_RLC = 3'd0,
    SK_RRC = 3'd1,
    SK_RL  = 3'd2,
    SK_RR  = 3'd3,
    SK_SLA = 3'd4,
    SK_SRA = 3'd5,
    SK_SLL = 3'd6,
    SK_SRL = 3'd7
  } shift_kind_t;

  // Write-back from the execute logic to the register file and flag register.
  typedef struct packed {
    logic       en;       // an instruction completes this cycle
    logic       reg_we;   // the selected register takes the result
    logic [2:0] sel;
    logic [7:0] data;
    logic [7:0] flags;
  } wb_t;

endpackage

/* src/cbsu_regs.sv */
// Register file (B, C, D, E, H, L, A) and flag register of the unit.
// Depends on cbsu_pkg for the write-back struct.
module cbsu_regs
  import cbsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] rd_sel,
  output logic [7:0] rd_data,
  output logic [7:0] flags,
  input  wb_t        wb
);

  logic [7:0] rf_r [8];
  logic [7:0] flags_r;

  // Registers and flags update when an instruction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        rf_r[i] <= 8'h00;
      end
      flags_r <= 8'h00;
    end else if (wb.en) begin
      flags_r <= wb.flags;
      if (wb.reg_we) begin
        rf_r[wb.sel] <= wb.data;
      end
    end
  end

  // Single read port for the operand.
  assign rd_data = rf_r[rd_sel];
  assign flags   = flags_r;

endmodule

/* src/cbsu_alu.sv */
// Execute logic: rotate/shift, BIT, RES and SET on one operand byte.
// Depends on cbsu_pkg for classes, shift kinds and flag positions.
module cbsu_alu
  import cbsu_pkg::*;
(
  input  logic [7:0] op,
  input  logic [7:0] memory_byte,
  input  logic [7:0] reg_data,
  input  logic [7:0] flags_in,
  output logic       write_memory,
  output logic       reg_we,
  output logic [7:0] result_byte,
  output logic [7:0] flags_out
);

  logic [2:0]  sel;
  logic [2:0]  mid;
  logic        is_mem;
  logic [7:0]  v;
  logic [7:0]  sh_r;
  logic        sh_c;
  logic [7:0]  sh_flags;
  logic [7:0]  bit_mask;
  logic        changes;

  assign sel      = op[2:0];
  assign mid      = op[5:3];
  assign is_mem   = (sel == SelMemory);
  assign v        = is_mem ? memory_byte : reg_data;
  assign bit_mask = 8'h01 << mid;

  // Rotate and shift datapath; carry takes the bit shifted out.
  always_comb begin
    sh_r = v;
    sh_c = 1'b0;
    unique case (shift_kind_t'(mid))
      SK_RLC: begin sh_c = v[7]; sh_r = {v[6:0], v[7]};           end
      SK_RRC: begin sh_c = v[0]; sh_r = {v[0], v[7:1]};           end
      SK_RL:  begin sh_c = v[7]; sh_r = {v[6:0], flags_in[FlagC]}; end
      SK_RR:  begin sh_c = v[0]; sh_r = {flags_in[FlagC], v[7:1]}; end
      SK_SLA: begin sh_c = v[7]; sh_r = {v[6:0], 1'b0};           end
      SK_SRA: begin sh_c = v[0]; sh_r = {v[7], v[7:1]};           end
      SK_SLL: begin sh_c = v[7]; sh_r = {v[6:0], 1'b1};           end
      SK_SRL: begin sh_c = v[0]; sh_r = {1'b0, v[7:1]};           end
    endcase
  end

  // Shift flags: S, Z, even parity and carry; H and N cleared.
  always_comb begin
    sh_flags        = flags_in & FlagKeepMask;
    sh_flags[FlagS] = sh_r[7];
    sh_flags[FlagZ] = (sh_r == 8'h00);
    sh_flags[FlagP] = ~^sh_r;
    sh_flags[FlagC] = sh_c;
  end

  // Class select for result and flags.
  always_comb begin
    result_byte = v;
    flags_out   = flags_in;
    changes     = 1'b1;
    unique case (cls_t'(op[7:6]))
      CLS_SHIFT: begin
        result_byte = sh_r;
        flags_out   = sh_flags;
      end
      CLS_BIT: begin
        changes          = 1'b0;
        flags_out[FlagZ] = ~|(v & bit_mask);
        flags_out[FlagH] = 1'b1;
        flags_out[FlagN] = 1'b0;
      end
      CLS_RES: result_byte = v & ~bit_mask;
      CLS_SET: result_byte = v | bit_mask;
    endcase
  end

  assign write_memory = changes & is_mem;
  assign reg_we       = changes & ~is_mem;

endmodule

/* src/cb_prefix_bit_shift_unit_top.sv */
// Top level of the CB-prefix bit and shift unit.
// Depends on cbsu_pkg, cbsu_regs and cbsu_alu.

// Executes the second byte of CB-prefixed instructions (rotate/shift, BIT,
// RES, SET) on one of seven internal registers or on a memory byte supplied
// with the word. One word is accepted per clock cycle while in_stall is low
// and each word gives exactly one result word, which passes through the
// input register and then the result register, and is taken at a clock
// edge when the output is not stalled. The one level of execute logic
// between these registers reads and writes the register file and flag
// register; successive words see each other's register and flag updates
// with no bubble. When out_stall holds a result, one more word waits in
// the input register before in_stall rises. Reset clears all registers
// and flags to zero.
module cb_prefix_bit_shift_unit_top
  import cbsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_op,
  input  logic [7:0] in_memory_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_write_memory,
  output logic [7:0] out_result_byte,
  output logic [7:0] out_flags_out
);

  logic       s1_vld_r;
  logic [7:0] op_r;
  logic [7:0] mem_r;
  logic       out_vld_r;
  logic       wmem_r;
  logic [7:0] res_r;
  logic [7:0] flg_r;

  logic       s1_go;
  logic       in_take;
  logic [7:0] rd_data;
  logic [7:0] flags_cur;
  logic       alu_wmem;
  logic       alu_reg_we;
  logic [7:0] alu_res;
  logic [7:0] alu_flags;
  wb_t        wb;

  // Handshake: the input word moves on when the result register is free.
  assign s1_go    = s1_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = s1_vld_r & ~s1_go;
  assign in_take  = in_valid & ~in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_take | (s1_vld_r & ~s1_go);
    end
    if (in_take) begin
      op_r  <= in_op;
      mem_r <= in_memory_byte;
    end
  end

  cbsu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_sel  (op_r[2:0]),
    .rd_data (rd_data),
    .flags   (flags_cur),
    .wb      (wb)
  );

  cbsu_alu u_alu (
    .op           (op_r),
    .memory_byte  (mem_r),
    .reg_data     (rd_data),
    .flags_in     (flags_cur),
    .write_memory (alu_wmem),
    .reg_we       (alu_reg_we),
    .result_byte  (alu_res),
    .flags_out    (alu_flags)
  );

  // Architectural update happens when the word enters the result register.
  assign wb.en     = s1_go;
  assign wb.reg_we = alu_reg_we;
  assign wb.sel    = op_r[2:0];
  assign wb.data   = alu_res;
  assign wb.flags  = alu_flags;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s1_go | (out_vld_r & out_stall);
    end
    if (s1_go) begin
      wmem_r <= alu_wmem;
      res_r  <= alu_res;
      flg_r  <= alu_flags;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_write_memory = wmem_r;
  assign out_result_byte  = res_r;
  assign out_flags_out    = flg_r;

endmodule

/* src/cbsu_checker.sv */
// Port-level checker for the CB-prefix bit and shift unit, bound to the top.
// Depends only on the top level's ports.
module cbsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_write_memory,
  input logic [7:0] out_result_byte,
  input logic [7:0] out_flags_out
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_byte)
      && $stable(out_flags_out) && $stable(out_write_memory))
    else $error("stalled result word changed");

  // The input side only stalls behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // After an accepted word has passed the input register, out_valid is high.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted word produced no result");

  // Flag bits 5 and 3 stay clear from reset on.
  a_flag_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_flags_out[5] && !out_flags_out[3])
    else $error("undocumented flag bit changed");

  // No result word right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cb_prefix_bit_shift_unit_top cbsu_checker u_cbsu_checker (.*);

/* tb/sv/cb_prefix_bit_shift_unit_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the CB-prefix bit and shift unit top level.
// Depends on cbsu_pkg and cb_prefix_bit_shift_unit_top; an internal model of the
// register file and flags predicts every result word.
module cb_prefix_bit_shift_unit_top_tb;
  import cbsu_pkg::*;

  // Register selects in opcode bits 2..0; the memory select comes from the package.
  typedef enum logic [2:0] {
    SEL_B = 3'd0,
    SEL_C = 3'd1,
    SEL_D = 3'd2,
    SEL_E = 3'd3,
    SEL_H = 3'd4,
    SEL_L = 3'd5,
    SEL_A = 3'd7
  } reg_sel_t;

  // One result word as the block should deliver it.
  typedef struct {
    logic       write_memory;
    logic [7:0] result_byte;
    logic [7:0] flags;
  } cb_result_t;

  localparam int unsigned IdleLimit = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_op;
  logic [7:0] in_memory_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_write_memory;
  logic [7:0] out_result_byte;
  logic [7:0] out_flags_out;

  // Model state and the words still owed by the block.
  logic [7:0] reg_file_model [8];
  logic [7:0] flag_model;
  cb_result_t expected_results [$];

  int errors = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_req = 0;

  cb_prefix_bit_shift_unit_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_memory_byte   (in_memory_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_memory (out_write_memory),
    .out_result_byte  (out_result_byte),
    .out_flags_out    (out_flags_out)
  );

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] mk_op(cls_t cls, logic [2:0] mid, logic [2:0] sel);
    return {cls, mid, sel};
  endfunction

  // Executes one instruction on the model state and returns the word it produces.
  function automatic cb_result_t predict_cb_result(logic [7:0] op, logic [7:0] mem);
    logic [2:0]  sel;
    logic [2:0]  mid;
    logic        is_mem;
    logic        changes;
    logic        carry_out;
    logic [7:0]  operand;
    logic [7:0]  res;
    logic [7:0]  flg;
    shift_kind_t kind;
    cb_result_t  word;
    sel       = op[2:0];
    mid       = op[5:3];
    kind      = shift_kind_t'(mid);
    is_mem    = (sel == SelMemory);
    operand   = is_mem ? mem : reg_file_model[sel];
    res       = operand;
    flg       = flag_model;
    changes   = 1'b1;
    carry_out = 1'b0;
    case (cls_t'(op[7:6]))
      CLS_SHIFT: begin
        case (kind)
          SK_RLC: begin carry_out = operand[7]; res = {operand[6:0], operand[7]}; end
          SK_RRC: begin carry_out = operand[0]; res = {operand[0], operand[7:1]}; end
          SK_RL:  begin carry_out = operand[7]; res = {operand[6:0], flg[FlagC]}; end
          SK_RR:  begin carry_out = operand[0]; res = {flg[FlagC], operand[7:1]}; end
          SK_SLA: begin carry_out = operand[7]; res = {operand[6:0], 1'b0}; end
          SK_SRA: begin carry_out = operand[0]; res = {operand[7], operand[7:1]}; end
          SK_SLL: begin carry_out = operand[7]; res = {operand[6:0], 1'b1}; end
          default: begin carry_out = operand[0]; res = {1'b0, operand[7:1]}; end
        endcase
        // Only the undocumented bits survive; S, Z and P come from the result, C from the carry, H and N clear.
        flg        = flg & FlagKeepMask;
        flg[FlagS] = (kind != SK_SRL) && res[7];
        flg[FlagZ] = (res == 8'h00);
        flg[FlagP] = ~^res;
        flg[FlagC] = carry_out;
      end
      CLS_BIT: begin
        changes    = 1'b0;
        flg[FlagZ] = ~operand[mid];
        flg[FlagH] = 1'b1;
        flg[FlagN] = 1'b0;
      end
      CLS_RES: res[mid] = 1'b0;
      default: res[mid] = 1'b1;
    endcase
    flag_model = flg;
    if (changes && !is_mem) begin
      reg_file_model[sel] = res;
    end
    word.write_memory = changes && is_mem;
    word.result_byte  = res;
    word.flags        = flg;
    return word;
  endfunction

  // Offers one word, after a random gap when tx_idle is set, and records its expected result on acceptance.
  task automatic send_word(logic [7:0] op, logic [7:0] mem);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_memory_byte <= mem;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_cb_result(op, mem));
  endtask

  // Result side: checks every accepted word and draws the stall before the next one.
  initial begin
    int stall_left;
    int hold_left;
    cb_result_t exp_word;
    stall_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: wm=%0b result=%02h flags=%02h", $time,
                   out_write_memory, out_result_byte, out_flags_out);
          errors++;
        end else begin
          exp_word = expected_results.pop_front();
          if (out_write_memory !== exp_word.write_memory) begin
            $display("%0t: write_memory mismatch: expected %0b, actual %0b", $time,
                     exp_word.write_memory, out_write_memory);
            errors++;
          end
          if (out_result_byte !== exp_word.result_byte) begin
            $display("%0t: result_byte mismatch: expected %02h, actual %02h", $time,
                     exp_word.result_byte, out_result_byte);
            errors++;
          end
          if (out_flags_out !== exp_word.flags) begin
            $display("%0t: flags_out mismatch: expected %02h, actual %02h", $time,
                     exp_word.flags, out_flags_out);
            errors++;
          end
        end
        stall_left = rx_idle ? $urandom_range(0, 16) : 0;
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Every class and shift kind, the operand extremes, the carry-in rotates,
  // SRL with bit 7 set, BIT on both end bits and every register select.
  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_word(mk_op(CLS_SET, 3'd7, SEL_B), 8'hA5);
    send_word(mk_op(CLS_SET, 3'd0, SEL_A), 8'h5A);
    send_word(mk_op(CLS_SHIFT, SK_RLC, SEL_B), 8'h00);
    send_word(mk_op(CLS_SHIFT, SK_RRC, SelMemory), 8'h01);
    send_word(mk_op(CLS_SHIFT, SK_RL, SelMemory), 8'hFF);
    send_word(mk_op(CLS_SHIFT, SK_RR, SelMemory), 8'h00);
    send_word(mk_op(CLS_SHIFT, SK_SLA, SelMemory), 8'h80);
    send_word(mk_op(CLS_SHIFT, SK_SRA, SelMemory), 8'h81);
    send_word(mk_op(CLS_SHIFT, SK_SLL, SelMemory), 8'h00);
    send_word(mk_op(CLS_SHIFT, SK_SRL, SelMemory), 8'hFF);
    send_word(mk_op(CLS_SHIFT, SK_SRL, SEL_A), 8'hFF);
    send_word(mk_op(CLS_BIT, 3'd7, SelMemory), 8'h80);
    send_word(mk_op(CLS_BIT, 3'd0, SelMemory), 8'hFE);
    send_word(mk_op(CLS_RES, 3'd7, SelMemory), 8'hFF);
    send_word(mk_op(CLS_SET, 3'd0, SelMemory), 8'h00);
    send_word(mk_op(CLS_SET, 3'd3, SEL_C), 8'h00);
    send_word(mk_op(CLS_SET, 3'd5, SEL_D), 8'hFF);
    send_word(mk_op(CLS_SET, 3'd1, SEL_E), 8'h00);
    send_word(mk_op(CLS_SET, 3'd6, SEL_H), 8'hFF);
    send_word(mk_op(CLS_SET, 3'd2, SEL_L), 8'h00);
    send_word(mk_op(CLS_BIT, 3'd3, SEL_C), 8'h00);
    send_word(mk_op(CLS_RES, 3'd3, SEL_C), 8'hFF);
    send_word(mk_op(CLS_SHIFT, SK_RR, SEL_C), 8'h00);
    send_word(mk_op(CLS_SHIFT, SK_SLL, SEL_E), 8'hFF);
    send_word(mk_op(CLS_BIT, 3'd4, SEL_A), 8'h00);
  endtask

  // The result side holds off for a long stretch while words keep coming,
  // so the block fills up and stalls its input.
  task automatic test_backpressure();
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 150;
    repeat (24) begin
      send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Random opcodes with extra weight on the memory operand; idling on each side
  // switches on and off in stretches.
  task automatic test_random();
    logic [7:0] op;
    int mode;
    for (int i = 0; i < 1000; i++) begin
      if (i % 125 == 0) begin
        mode    = (i / 125) % 4;
        tx_idle = (mode == 0) || (mode == 1);
        rx_idle = (mode == 0) || (mode == 2);
      end
      op = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        op[2:0] = SelMemory;
      end
      send_word(op, 8'($urandom_range(0, 255)));
    end
  endtask

  // Main sequence: reset, the tests in turn, then drain and report.
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_op          <= 8'h00;
    in_memory_byte <= 8'h00;
    for (int i = 0; i < 8; i++) begin
      reg_file_model[i] = 8'h00;
    end
    flag_model = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
